/* rtl/npq_pkg.sv */
// Shared types, palette base colours and blend functions for the palette quantizer.
// Depends on nothing; every other file of the block but npq_if imports it.
package npq_pkg;

  // Palette dimensions, clamped to the base colour tables
  localparam int FORE_COLOURS = 10;
  localparam int BACK_COLOURS = 9;
  localparam int SHADE_LEVELS = 3;

  localparam int FG_TABLE = 10;
  localparam int BG_TABLE = 9;
  localparam int SH_TABLE = 4;

  localparam int FG_USED = (FORE_COLOURS < 1) ? 1 :
                           ((FORE_COLOURS > FG_TABLE) ? FG_TABLE : FORE_COLOURS);
  localparam int BG_USED = (BACK_COLOURS < 1) ? 1 :
                           ((BACK_COLOURS > BG_TABLE) ? BG_TABLE : BACK_COLOURS);
  localparam int SH_USED = (SHADE_LEVELS < 1) ? 1 :
                           ((SHADE_LEVELS > SH_TABLE) ? SH_TABLE : SHADE_LEVELS);

  localparam int NUM_ENTRIES = FG_USED * BG_USED * SH_USED;

  // 3 * 255^2 fits in 18 bits; all ones is above any real distance
  localparam int DIST_W = 18;

  typedef logic [7:0] chan_t;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } rgb_t;

  typedef struct packed {
    logic [3:0] fore;
    logic [3:0] back;
    logic [1:0] shade;
  } tag_t;

  // What travels from cell to cell: the pixel and the best match so far
  typedef struct packed {
    logic              valid;
    rgb_t              pix;
    logic [DIST_W-1:0] best_dist;
    tag_t              tag;
  } token_t;

  localparam rgb_t FG_BASE [FG_TABLE] = '{
    '{8'd12,  8'd12,  8'd12},  '{8'd19,  8'd161, 8'd14},
    '{8'd204, 8'd204, 8'd204}, '{8'd118, 8'd118, 8'd118},
    '{8'd59,  8'd120, 8'd255}, '{8'd22,  8'd198, 8'd12},
    '{8'd97,  8'd214, 8'd214}, '{8'd231, 8'd72,  8'd86},
    '{8'd249, 8'd241, 8'd165}, '{8'd242, 8'd242, 8'd242}
  };

  localparam rgb_t BG_BASE [BG_TABLE] = '{
    '{8'd12,  8'd12,  8'd12},
    '{8'd204, 8'd204, 8'd204}, '{8'd118, 8'd118, 8'd118},
    '{8'd59,  8'd120, 8'd255}, '{8'd22,  8'd198, 8'd12},
    '{8'd97,  8'd214, 8'd214}, '{8'd231, 8'd72,  8'd86},
    '{8'd249, 8'd241, 8'd165}, '{8'd242, 8'd242, 8'd242}
  };

  // (f*w + b*(4-w)) >> 2, w in quarters
  function automatic chan_t mix_channel(chan_t f, chan_t b, logic [2:0] w);
    logic [9:0] acc;
    acc = 10'(f) * 10'(w) + 10'(b) * (10'd4 - 10'(w));
    return acc[9:2];
  endfunction

  // Blended colour of one palette entry
  function automatic rgb_t entry_rgb(tag_t t);
    rgb_t       fg;
    rgb_t       bg;
    rgb_t       c;
    logic [2:0] w;
    fg = (t.fore < 4'(FG_TABLE)) ? FG_BASE[t.fore] : '0;
    bg = (t.back < 4'(BG_TABLE)) ? BG_BASE[t.back] : '0;
    w = 3'd4 - 3'(t.shade);
    c.red   = mix_channel(fg.red,   bg.red,   w);
    c.green = mix_channel(fg.green, bg.green, w);
    c.blue  = mix_channel(fg.blue,  bg.blue,  w);
    return c;
  endfunction

endpackage

/* rtl/npq_if.sv */
// Stream interfaces of the palette quantizer: pixel in, match result out.
// Depends on nothing.
interface npq_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_red;
  logic [7:0] in_green;
  logic [7:0] in_blue;

  modport source(output valid, output in_red, output in_green, output in_blue,
                 input ready);
  modport sink(input valid, input in_red, input in_green, input in_blue,
               output ready);
endinterface

interface npq_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic [3:0] fore_index;
  logic [3:0] back_index;
  logic [1:0] shade_index;

  modport source(output valid, output out_red, output out_green, output out_blue,
                 output fore_index, output back_index, output shade_index,
                 input ready);
  modport sink(input valid, input out_red, input out_green, input out_blue,
               input fore_index, input back_index, input shade_index,
               output ready);
endinterface

/* rtl/npq_cell.sv */
// One cell of the match chain: compares the passing pixel with one palette entry.
// Depends on npq_pkg.
module npq_cell import npq_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   adv,
  input  rgb_t   entry_c,
  input  tag_t   entry_t,
  input  token_t tok_i,
  output token_t tok_o
);

  token_t      a_r;
  logic [15:0] sq_red_r;
  logic [15:0] sq_green_r;
  logic [15:0] sq_blue_r;
  logic [15:0] sq_red_nxt;
  logic [15:0] sq_green_nxt;
  logic [15:0] sq_blue_nxt;
  logic [DIST_W-1:0] sum;
  token_t      b_r;
  token_t      b_nxt;

  function automatic chan_t abs_diff(chan_t x, chan_t y);
    return (x > y) ? (x - y) : (y - x);
  endfunction

  // stage A: per-channel squared differences
  always_comb begin
    chan_t dr;
    chan_t dg;
    chan_t db;
    dr = abs_diff(tok_i.pix.red,   entry_c.red);
    dg = abs_diff(tok_i.pix.green, entry_c.green);
    db = abs_diff(tok_i.pix.blue,  entry_c.blue);
    sq_red_nxt   = 16'(dr) * 16'(dr);
    sq_green_nxt = 16'(dg) * 16'(dg);
    sq_blue_nxt  = 16'(db) * 16'(db);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_r        <= tok_i;
      sq_red_r   <= sq_red_nxt;
      sq_green_r <= sq_green_nxt;
      sq_blue_r  <= sq_blue_nxt;
    end
    if (!rst_n) begin
      a_r.valid <= 1'b0;
    end
  end

  // stage B: total distance, keep strictly better only (earliest wins ties)
  always_comb begin
    sum = DIST_W'(sq_red_r) + DIST_W'(sq_green_r) + DIST_W'(sq_blue_r);
    b_nxt = a_r;
    if (sum < a_r.best_dist) begin
      b_nxt.best_dist = sum;
      b_nxt.tag       = entry_t;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_r <= b_nxt;
    end
    if (!rst_n) begin
      b_r.valid <= 1'b0;
    end
  end

  assign tok_o = b_r;

`ifndef ASSERT_OFF
  // a beat in stage A moves on to stage B
  a_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && a_r.valid) |=> b_r.valid)
    else $error("npq_cell: beat lost between stages");

  // the best distance never grows across a cell
  dist_no_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && a_r.valid) |=> (b_r.best_dist <= $past(a_r.best_dist)))
    else $error("npq_cell: best distance grew");

  // a stalled chain holds its beats
  hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> ($stable(b_r) && $stable(a_r.valid)))
    else $error("npq_cell: cell changed while stalled");
`endif

endmodule

/* rtl/npq_out.sv */
// Result register of the palette quantizer: turns the winning tag into a colour.
// Depends on npq_pkg and npq_res_if; drives the advance enable of the chain.
module npq_out import npq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  token_t    tok_i,
  output logic      adv,
  npq_res_if.source out_px
);

  logic res_valid_r;
  rgb_t res_rgb_r;
  tag_t res_tag_r;

  // chain moves whenever the result slot is free or being taken
  assign adv = !res_valid_r || out_px.ready;

  always_ff @(posedge clk) begin
    if (adv) begin
      res_rgb_r <= entry_rgb(tok_i.tag);
      res_tag_r <= tok_i.tag;
    end
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (adv) begin
      res_valid_r <= tok_i.valid;
    end
  end

  assign out_px.valid       = res_valid_r;
  assign out_px.out_red     = res_rgb_r.red;
  assign out_px.out_green   = res_rgb_r.green;
  assign out_px.out_blue    = res_rgb_r.blue;
  assign out_px.fore_index  = res_tag_r.fore;
  assign out_px.back_index  = res_tag_r.back;
  assign out_px.shade_index = res_tag_r.shade;

endmodule

/* rtl/nearest_palette_colour_quantizer.sv */
// Nearest palette colour quantizer: a pixel enters each cycle the result side is not
// stalled, so the sustained rate is one pixel per cycle. Its match passes through a
// chain of match cells, one per entry of the 270-entry palette, each two register
// stages deep (squared channel differences, then distance sum and compare), then the
// result register; a stalled result freezes the whole chain. Ties go to the earliest
// entry in foreground, background, shade order.
// Depends on npq_pkg, npq_if, npq_cell and npq_out.
module nearest_palette_colour_quantizer import npq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  npq_pix_if.sink   in_px,
  npq_res_if.source out_px
);

  token_t chain [NUM_ENTRIES+1];
  logic   adv;

  assign in_px.ready = adv;

  // head of the chain: fresh pixel, no match yet
  always_comb begin
    chain[0].valid     = in_px.valid;
    chain[0].pix.red   = in_px.in_red;
    chain[0].pix.green = in_px.in_green;
    chain[0].pix.blue  = in_px.in_blue;
    chain[0].best_dist = '1;
    chain[0].tag       = '0;
  end

  // one cell per palette entry, in foreground, background, shade order
  for (genvar k = 0; k < NUM_ENTRIES; k++) begin : g_cell
    localparam int FI = k / (BG_USED * SH_USED);
    localparam int BI = (k / SH_USED) % BG_USED;
    localparam int SI = k % SH_USED;
    localparam tag_t ETAG = '{fore: 4'(FI), back: 4'(BI), shade: 2'(SI)};
    localparam rgb_t ECOL = entry_rgb(ETAG);

    npq_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .entry_c (ECOL),
      .entry_t (ETAG),
      .tok_i   (chain[k]),
      .tok_o   (chain[k+1])
    );
  end

  npq_out u_out (
    .clk    (clk),
    .rst_n  (rst_n),
    .tok_i  (chain[NUM_ENTRIES]),
    .adv    (adv),
    .out_px (out_px)
  );

endmodule

/* verif/npq_tb_pkg.sv */
// Scoreboard for the palette quantizer bench: owns its own blended palette
// and a queue of predicted matches. Depends on npq_pkg for the pixel and tag types.
package npq_tb_pkg;
  import npq_pkg::*;

  localparam int PAL_FG = 10;
  localparam int PAL_BG = 9;
  localparam int PAL_SH = 3;
  localparam int PAL_N  = PAL_FG * PAL_BG * PAL_SH;

  typedef struct packed {
    rgb_t colour;
    tag_t tag;
  } match_t;

  class quantizer_scoreboard;
    rgb_t   palette[PAL_N];
    tag_t   palette_tag[PAL_N];
    match_t expected_matches[$];
    int     errors;

    // Base colours in index order; the background list lacks the second one, a green
    static const rgb_t fg_colours[PAL_FG] = '{
      '{8'd12,  8'd12,  8'd12},  '{8'd19,  8'd161, 8'd14},
      '{8'd204, 8'd204, 8'd204}, '{8'd118, 8'd118, 8'd118},
      '{8'd59,  8'd120, 8'd255}, '{8'd22,  8'd198, 8'd12},
      '{8'd97,  8'd214, 8'd214}, '{8'd231, 8'd72,  8'd86},
      '{8'd249, 8'd241, 8'd165}, '{8'd242, 8'd242, 8'd242}
    };
    static const rgb_t bg_colours[PAL_BG] = '{
      '{8'd12,  8'd12,  8'd12},
      '{8'd204, 8'd204, 8'd204}, '{8'd118, 8'd118, 8'd118},
      '{8'd59,  8'd120, 8'd255}, '{8'd22,  8'd198, 8'd12},
      '{8'd97,  8'd214, 8'd214}, '{8'd231, 8'd72,  8'd86},
      '{8'd249, 8'd241, 8'd165}, '{8'd242, 8'd242, 8'd242}
    };

    // Palette is built fg-major, then bg, then shade: the tie-break order
    function new();
      int k;
      int w;
      k = 0;
      errors = 0;
      for (int f = 0; f < PAL_FG; f++) begin
        for (int b = 0; b < PAL_BG; b++) begin
          for (int s = 0; s < PAL_SH; s++) begin
            w = 4 - s;
            palette[k].red   = 8'((fg_colours[f].red * w + bg_colours[b].red * (4 - w)) >> 2);
            palette[k].green = 8'((fg_colours[f].green * w +
                                   bg_colours[b].green * (4 - w)) >> 2);
            palette[k].blue  = 8'((fg_colours[f].blue * w +
                                   bg_colours[b].blue * (4 - w)) >> 2);
            palette_tag[k] = '{fore: 4'(f), back: 4'(b), shade: 2'(s)};
            k++;
          end
        end
      end
    endfunction

    // Exhaustive search; strict less-than keeps the earliest entry on ties
    function match_t nearest_entry(rgb_t p);
      int unsigned best_d;
      int unsigned d;
      int          dr;
      int          dg;
      int          db;
      match_t      m;
      best_d = 0;
      m = '0;
      for (int k = 0; k < PAL_N; k++) begin
        dr = int'(p.red) - int'(palette[k].red);
        dg = int'(p.green) - int'(palette[k].green);
        db = int'(p.blue) - int'(palette[k].blue);
        d = dr * dr + dg * dg + db * db;
        if (k == 0 || d < best_d) begin
          best_d = d;
          m.colour = palette[k];
          m.tag = palette_tag[k];
        end
      end
      return m;
    endfunction

    function void note_pixel(rgb_t p);
      expected_matches.insert(expected_matches.size(), nearest_entry(p));
    endfunction

    function int pending();
      return expected_matches.size();
    endfunction

    function void check_field(string name, int exp_v, int act_v, longint unsigned now);
      if (exp_v != act_v) begin
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", now, name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_match(match_t got, longint unsigned now);
      match_t want;
      if (expected_matches.size() == 0) begin
        $display("%0t ns: unexpected result beat, expected none, actual rgb=%h tag=%h",
                 now, got.colour, got.tag);
        errors++;
        return;
      end
      want = expected_matches.pop_front();
      check_field("out_red",     want.colour.red,   got.colour.red,   now);
      check_field("out_green",   want.colour.green, got.colour.green, now);
      check_field("out_blue",    want.colour.blue,  got.colour.blue,  now);
      check_field("fore_index",  want.tag.fore,     got.tag.fore,     now);
      check_field("back_index",  want.tag.back,     got.tag.back,     now);
      check_field("shade_index", want.tag.shade,    got.tag.shade,    now);
    endfunction
  endclass

endpackage

/* verif/tb.sv */
// Top-level bench for nearest_palette_colour_quantizer: drives pixel beats,
// checks every match beat against the scoreboard in npq_tb_pkg.
// Depends on npq_pkg, npq_if, npq_tb_pkg and the block's RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import npq_pkg::*;
  import npq_tb_pkg::*;

  localparam int HOLD_CYCLES    = 1200;   // longer than the 541-deep chain
  localparam int SETTLE_CYCLES  = 600;    // covers the latency of the chain
  localparam int WATCHDOG_LIMIT = 10000;

  logic clk = 1'b0;
  logic rst_n;

  npq_pix_if pix_ch();
  npq_res_if res_ch();

  nearest_palette_colour_quantizer u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_px  (pix_ch),
    .out_px (res_ch)
  );

  quantizer_scoreboard match_board;
  int tx_idle_pct;
  int rx_idle_pct;
  int hold_count = 0;
  int hold_seen  = 0;
  int hold_left  = 0;
  int quiet_cycles = 0;

  always #2 clk = ~clk;

  // Result side: random back-pressure, plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      res_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      res_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_count != hold_seen) begin
      hold_seen <= hold_count;
      hold_left <= HOLD_CYCLES - 1;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Result monitor
  always @(posedge clk) begin
    match_t got;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      got.colour.red   = res_ch.out_red;
      got.colour.green = res_ch.out_green;
      got.colour.blue  = res_ch.out_blue;
      got.tag.fore     = res_ch.fore_index;
      got.tag.back     = res_ch.back_index;
      got.tag.shade    = res_ch.shade_index;
      match_board.check_match(got, $time);
    end
  end

  // Watchdog: too long without any beat on either side
  always @(posedge clk) begin
    if (!rst_n || (pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One pixel beat, preceded by random idle cycles
  task automatic send_pixel(rgb_t p);
    while ($urandom_range(99) < tx_idle_pct) begin
      pix_ch.valid <= 1'b0;
      @(posedge clk);
    end
    pix_ch.valid    <= 1'b1;
    pix_ch.in_red   <= p.red;
    pix_ch.in_green <= p.green;
    pix_ch.in_blue  <= p.blue;
    @(posedge clk);
    while (!pix_ch.ready) @(posedge clk);
    match_board.note_pixel(p);
  endtask

  // Sender stops until every predicted match has come back
  task automatic drain_matches();
    pix_ch.valid <= 1'b0;
    do @(posedge clk); while (match_board.pending() != 0);
  endtask

  function automatic chan_t jitter(chan_t c);
    int v;
    v = int'(c) + int'($urandom_range(12)) - 6;
    return (v < 0) ? 8'd0 : ((v > 255) ? 8'd255 : 8'(v));
  endfunction

  // Mostly pixels near a palette entry (close calls and ties), the rest uniform
  function automatic rgb_t random_pixel();
    rgb_t p;
    int   k;
    int   pick;
    pick = $urandom_range(99);
    k = $urandom_range(PAL_N - 1);
    if (pick < 45) begin
      p = {8'($urandom), 8'($urandom), 8'($urandom)};
    end else if (pick < 90) begin
      p.red   = jitter(match_board.palette[k].red);
      p.green = jitter(match_board.palette[k].green);
      p.blue  = jitter(match_board.palette[k].blue);
    end else begin
      p = match_board.palette[k];
    end
    return p;
  endfunction

  initial begin
    rgb_t directed[$];
    pix_ch.valid    <= 1'b0;
    pix_ch.in_red   <= 8'd0;
    pix_ch.in_green <= 8'd0;
    pix_ch.in_blue  <= 8'd0;
    rst_n           <= 1'b0;
    match_board = new();
    tx_idle_pct = 34;
    rx_idle_pct = 49;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Channel extremes and alternating bit patterns
    directed.insert(directed.size(), '{8'd0,   8'd0,   8'd0});
    directed.insert(directed.size(), '{8'd255, 8'd255, 8'd255});
    directed.insert(directed.size(), '{8'd255, 8'd0,   8'd0});
    directed.insert(directed.size(), '{8'd0,   8'd255, 8'd0});
    directed.insert(directed.size(), '{8'd0,   8'd0,   8'd255});
    directed.insert(directed.size(), '{8'd255, 8'd255, 8'd0});
    directed.insert(directed.size(), '{8'd0,   8'd255, 8'd255});
    directed.insert(directed.size(), '{8'd255, 8'd0,   8'd255});
    directed.insert(directed.size(), '{8'h55,  8'hAA,  8'h55});
    directed.insert(directed.size(), '{8'hAA,  8'h55,  8'hAA});
    // Exact base colours: grey ones recur across shades, so ties pick the first
    foreach (match_board.fg_colours[i]) begin
      directed.insert(directed.size(), match_board.fg_colours[i]);
    end
    // Third, last and a few blended entries
    directed.insert(directed.size(), match_board.palette[2]);
    directed.insert(directed.size(), match_board.palette[PAL_N - 1]);
    directed.insert(directed.size(), match_board.palette[37]);
    directed.insert(directed.size(), match_board.palette[148]);
    foreach (directed[i]) send_pixel(directed[i]);

    // Phase 1: sender idles a third of the time, receiver about half
    repeat (300) send_pixel(random_pixel());
    drain_matches();

    // Phase 2: the other way round
    tx_idle_pct = 49;
    rx_idle_pct = 34;
    repeat (325) send_pixel(random_pixel());
    drain_matches();

    // Phase 3: no idling; a long receiver hold-off fills the chain first
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_count = hold_count + 1;
    repeat (700) send_pixel(random_pixel());
    pix_ch.valid <= 1'b0;

    while (match_board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (match_board.errors == 0 && match_board.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/npq_pkg.sv
rtl/npq_if.sv
rtl/npq_cell.sv
rtl/npq_out.sv
rtl/nearest_palette_colour_quantizer.sv
verif/npq_tb_pkg.sv
verif/tb.sv
